### hw/rtl/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types and constants for the Ising Metropolis spin update block:
// lattice geometry, channel payloads and controller/datapath command bundles.
// ----------------------------------------------------------------------------
package imsu_pkg;

  // Lattice geometry (side is a power of two so wrap is plain modular math)
  localparam int unsigned SIDE_LOG2 = 6;
  localparam int unsigned SIDE      = 1 << SIDE_LOG2;
  localparam int unsigned CELL_AW   = 2 * SIDE_LOG2;
  localparam int unsigned CELLS     = 1 << CELL_AW;

  // Field widths
  localparam int unsigned SITE_W = 12;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned PROD_W = 4;

  // Site width wide enough to hold any cell index or any input site
  localparam int unsigned EXT_W = (CELL_AW > SITE_W) ? CELL_AW : SITE_W;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Mode codes
  localparam logic MODE_TRIAL = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Spin RAM address source
  typedef enum logic [2:0] {
    NB_UP,
    NB_DOWN,
    NB_LEFT,
    NB_RIGHT,
    NB_CENTER
  } nb_sel_e;

  // Input item
  typedef struct packed {
    logic              mode;
    logic [SITE_W-1:0] site;
    logic [FRAC_W-1:0] random_fraction;
  } in_t;

  // Result item
  typedef struct packed {
    logic                     flipped;
    logic                     spin_after;
    logic signed [PROD_W-1:0] local_product;
  } out_t;

  // Controller -> datapath
  typedef struct packed {
    logic    clear_wr;   // write +1 at clear counter, advance counter
    logic    load;       // capture input item, reset neighbour count
    logic    rd_en;      // issue spin RAM read
    nb_sel_e rd_sel;     // which site to read
    logic    use_input;  // address from input payload instead of held site
    logic    acc_en;     // add last read spin into neighbour count
    logic    finish;     // decide, write back, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;    // clear counter on last cell
    logic out_full;      // result register holds an untaken result
  } status_t;

endpackage

### hw/rtl/imsu_ctrl.sv
// ----------------------------------------------------------------------------
// imsu_ctrl
// Sequencer for the spin update: clearing pass after reset, then per input
// item four neighbour reads, one center read and a decide/write-back step.
// ----------------------------------------------------------------------------
module imsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  imsu_pkg::status_t status_i,
  output imsu_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DOWN,
    S_LEFT,
    S_RIGHT,
    S_CENTER,
    S_DECIDE
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.rd_sel    = imsu_pkg::NB_UP;
    in_ready_o      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.use_input = 1'b1;
          cmd_o.rd_sel    = imsu_pkg::NB_UP;
          state_d         = S_DOWN;
        end
      end
      S_DOWN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = imsu_pkg::NB_DOWN;
        cmd_o.acc_en = 1'b1;
        state_d      = S_LEFT;
      end
      S_LEFT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = imsu_pkg::NB_LEFT;
        cmd_o.acc_en = 1'b1;
        state_d      = S_RIGHT;
      end
      S_RIGHT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = imsu_pkg::NB_RIGHT;
        cmd_o.acc_en = 1'b1;
        state_d      = S_CENTER;
      end
      S_CENTER: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = imsu_pkg::NB_CENTER;
        cmd_o.acc_en = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        // hold until the result register can take the new result
        cmd_o.rd_sel = imsu_pkg::NB_CENTER;
        if (!status_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/imsu_datapath.sv
// ----------------------------------------------------------------------------
// imsu_datapath
// Single-port spin RAM, clear counter, neighbour counter, flip decision and
// the result register.
// ----------------------------------------------------------------------------
module imsu_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  imsu_pkg::cmd_t                 cmd_i,
  output imsu_pkg::status_t              status_o,
  input  imsu_pkg::in_t                  in_data_i,
  input  logic [imsu_pkg::THR_W-1:0]     thr_two_i,
  input  logic [imsu_pkg::THR_W-1:0]     thr_four_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output imsu_pkg::out_t                 out_data_o
);

  localparam int unsigned LOG2 = imsu_pkg::SIDE_LOG2;
  localparam int unsigned AW   = imsu_pkg::CELL_AW;
  localparam int unsigned XW   = imsu_pkg::EXT_W;

  // Spin store: 1 = +1, 0 = -1
  logic mem [imsu_pkg::CELLS];
  logic rdata_q;

  logic [AW-1:0]                 clr_cnt_q;
  imsu_pkg::in_t                 item_q;
  logic [2:0]                    cnt_q;
  logic                          out_valid_q;
  imsu_pkg::out_t                out_data_q;

  logic [XW-1:0]                 base_ext;
  logic [AW-1:0]                 base;
  logic [LOG2-1:0]               row;
  logic [LOG2-1:0]               col;
  logic [AW-1:0]                 nb_addr;
  logic [AW-1:0]                 ram_addr;
  logic                          ram_we;
  logic                          ram_wdata;
  logic [XW-1:0]                 site_ext;
  logic                          in_range;
  logic [imsu_pkg::PROD_W-1:0]   sum;
  logic [imsu_pkg::PROD_W-1:0]   prod;
  logic                          prod_le0;
  logic                          flip;
  imsu_pkg::out_t                result;

  // Neighbour addressing with periodic wrap
  assign base_ext = cmd_i.use_input ? XW'(in_data_i.site) : XW'(item_q.site);
  assign base     = base_ext[AW-1:0];
  assign row      = base[AW-1:LOG2];
  assign col      = base[LOG2-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      imsu_pkg::NB_UP:     nb_addr = {row - LOG2'(1), col};
      imsu_pkg::NB_DOWN:   nb_addr = {row + LOG2'(1), col};
      imsu_pkg::NB_LEFT:   nb_addr = {row, col - LOG2'(1)};
      imsu_pkg::NB_RIGHT:  nb_addr = {row, col + LOG2'(1)};
      imsu_pkg::NB_CENTER: nb_addr = base;
      default:             nb_addr = base;
    endcase
  end

  // Flip decision; rdata_q holds the center spin in the decide step
  assign site_ext = XW'(item_q.site);
  assign in_range = {1'b0, site_ext} < (XW + 1)'(imsu_pkg::CELLS);
  assign sum      = {1'b0, cnt_q} + {1'b0, cnt_q} - imsu_pkg::PROD_W'(4);
  assign prod     = rdata_q ? sum : (imsu_pkg::PROD_W'(0) - sum);
  assign prod_le0 = prod[imsu_pkg::PROD_W-1] || (prod == '0);

  always_comb begin
    flip = 1'b0;
    if (item_q.mode == imsu_pkg::MODE_TRIAL && in_range) begin
      if (prod_le0) begin
        flip = 1'b1;
      end else if (prod == imsu_pkg::PROD_W'(2)) begin
        flip = item_q.random_fraction < thr_two_i;
      end else begin
        flip = item_q.random_fraction < thr_four_i;
      end
    end
  end

  always_comb begin
    result               = '0;
    if (in_range) begin
      result.flipped       = flip;
      result.spin_after    = rdata_q ^ flip;
      result.local_product = signed'(prod);
    end
  end

  // Spin RAM port: clear writes, write-back, or one read
  assign ram_addr  = cmd_i.clear_wr ? clr_cnt_q :
                     cmd_i.finish   ? site_ext[AW-1:0] : nb_addr;
  assign ram_we    = cmd_i.clear_wr || (cmd_i.finish && flip);
  assign ram_wdata = cmd_i.clear_wr ? 1'b1 : ~rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem[ram_addr] <= ram_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[ram_addr];
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // Clear counter, neighbour counter, result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.acc_en) begin
        cnt_q <= cnt_q + {2'b00, rdata_q};
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= result;
    end
  end

  assign status_o.clear_done = (clr_cnt_q == AW'(imsu_pkg::CELLS - 1));
  assign status_o.out_full   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;

endmodule

### hw/rtl/ising_metropolis_spin_update_top.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_top
// Metropolis single-spin update on a periodic square lattice of one-bit
// spins, with a spin read mode and two APB threshold registers.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_data_i  (imsu_pkg::in_t)
//   out      out  out_valid_o / out_ready_i out_data_o (imsu_pkg::out_t)
//   cfg      in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A new item is taken only after the decide step of the previous one: five
// spin reads and the write-back share the single port of the spin RAM.
// After reset a clearing pass writes +1 to all 4096 cells, one per cycle;
// in_ready_o stays low during the pass, the cfg port works meanwhile.
// The result register frees the input side; the decide step holds only
// while an earlier result is still untaken.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  imsu_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output imsu_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imsu_pkg::CFG_AW-1:0]   paddr,
  input  logic [imsu_pkg::CFG_DW-1:0]   pwdata,
  output logic [imsu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  // Register select (address bit 2)
  localparam logic REG_ACCEPT_TWO  = 1'b0;
  localparam logic REG_ACCEPT_FOUR = 1'b1;

  logic [imsu_pkg::THR_W-1:0] thr_two_q;
  logic [imsu_pkg::THR_W-1:0] thr_four_q;
  logic                       cfg_wr;
  imsu_pkg::cmd_t             cmd;
  imsu_pkg::status_t          status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_two_q  <= '0;
      thr_four_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ACCEPT_TWO) begin
        thr_two_q <= pwdata[imsu_pkg::THR_W-1:0];
      end
      if (paddr[2] == REG_ACCEPT_FOUR) begin
        thr_four_q <= pwdata[imsu_pkg::THR_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ACCEPT_FOUR) ? imsu_pkg::CFG_DW'(thr_four_q)
                                                : imsu_pkg::CFG_DW'(thr_two_q);

  // Sequencer
  imsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Spin RAM and decision logic
  imsu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .thr_two_i   (thr_two_q),
    .thr_four_i  (thr_four_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
